[design/dwi_pkg.sv]
package dwi_pkg;

  // datapath word and unit widths
  localparam int DW   = 112;
  localparam int MW   = 56;
  localparam int MDIG = 8;
  localparam int MUL_STEPS = MW / MDIG;
  localparam int LW   = 80;
  localparam int LGW  = 37;
  localparam int FRAC_BITS = 30;
  localparam int SQW  = 84;
  localparam int RTW  = SQW / 2;
  localparam int DVW  = 104;
  localparam int DSW  = 48;
  localparam int QW   = DVW - FRAC_BITS;
  localparam int SUMW = 40;
  localparam int PCW  = 6;

  localparam logic [33:0] KE_Q30        = 34'd10912973667; // 12.0 + log2(0.28), Q30
  localparam logic [27:0] TWOPI_LN2_Q24 = 28'd152080770;
  localparam logic [22:0] LOG2E_Q22     = 23'd6051102;
  localparam logic [23:0] UF_RESET      = 24'd143059;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [3:0] {
    OP_WAIT, OP_LD, OP_MUL, OP_ADD, OP_SUB, OP_SHR1, OP_SHL16, OP_SQRT,
    OP_LOG, OP_DIV, OP_ACC, OP_SETBAD, OP_JMP, OP_NEXTAX, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {R0, R1, R2, R3, RW} reg_t;

  typedef enum logic [3:0] {
    S_D1, S_D2, S_K1, S_K2, S_LEN, S_RW, S_KE, S_SKIN, S_UF, S_TWOPI,
    S_SUMX, S_SUMY, S_SUMZ
  } src_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_INBAD, C_ZERO, C_NONPOS, C_NOTLAST, C_BAD
  } cond_t;

  typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_ITER} lg_state_t;

  typedef struct packed {
    op_t            op;
    reg_t           dst;
    reg_t           sa;
    reg_t           sb;
    src_t           src;
    cond_t          cond;
    logic [PCW-1:0] tgt;
  } cw_t;

  typedef struct packed {
    logic [23:0] lx, ly, lz;
    logic [23:0] sx, sy, sz;
    logic [23:0] kx, ky, kz;
    logic [15:0] rw;
    logic [13:0] skin;
  } seg_t;

  // program labels
  localparam logic [PCW-1:0] L_IDLE  = 6'd0;
  localparam logic [PCW-1:0] L_AXIS  = 6'd4;
  localparam logic [PCW-1:0] L_AXBAD = 6'd44;
  localparam logic [PCW-1:0] L_NEXT  = 6'd45;
  localparam logic [PCW-1:0] L_LAST  = 6'd46;
  localparam logic [PCW-1:0] L_EMIT  = 6'd57;
  localparam logic [PCW-1:0] L_BADIN = 6'd58;

  function automatic cw_t mk(op_t op, reg_t d, reg_t a, reg_t b, src_t s, cond_t c,
                             logic [PCW-1:0] t);
    cw_t w;
    w.op = op; w.dst = d; w.sa = a; w.sb = b; w.src = s; w.cond = c; w.tgt = t;
    return w;
  endfunction

  function automatic cw_t ld(reg_t d, src_t s);
    return mk(OP_LD, d, R0, R0, s, C_ALWAYS, L_IDLE);
  endfunction

  function automatic cw_t alu(op_t op, reg_t d, reg_t a, reg_t b);
    return mk(op, d, a, b, S_D1, C_ALWAYS, L_IDLE);
  endfunction

  function automatic cw_t jmp(op_t op, cond_t c, reg_t a, logic [PCW-1:0] t);
    return mk(op, R0, a, R0, S_D1, c, t);
  endfunction

  function automatic cw_t ucode(logic [PCW-1:0] pc);
    cw_t w;
    case (pc)
      6'd0:  w = jmp(OP_WAIT, C_ALWAYS, R0, L_IDLE);
      6'd1:  w = jmp(OP_JMP, C_INBAD, R0, L_BADIN);
      6'd2:  w = ld(RW, S_RW);
      6'd3:  w = alu(OP_LOG, RW, RW, R0);
      // per-axis body
      6'd4:  w = ld(R0, S_D1);
      6'd5:  w = alu(OP_MUL, R0, R0, R0);
      6'd6:  w = ld(R1, S_K2);
      6'd7:  w = alu(OP_MUL, R0, R0, R1);
      6'd8:  w = ld(R1, S_D2);
      6'd9:  w = alu(OP_MUL, R1, R1, R1);
      6'd10: w = ld(R2, S_K1);
      6'd11: w = alu(OP_MUL, R1, R1, R2);
      6'd12: w = alu(OP_ADD, R0, R0, R1);
      6'd13: w = jmp(OP_JMP, C_ZERO, R0, L_AXBAD);
      6'd14: w = alu(OP_LOG, R0, R0, R0);
      6'd15: w = alu(OP_SHR1, R0, R0, R0);
      6'd16: w = ld(R1, S_K1);
      6'd17: w = alu(OP_SHL16, R1, R1, R1);
      6'd18: w = alu(OP_SQRT, R1, R1, R1);
      6'd19: w = ld(R2, S_K2);
      6'd20: w = alu(OP_SHL16, R2, R2, R2);
      6'd21: w = alu(OP_SQRT, R2, R2, R2);
      6'd22: w = alu(OP_ADD, R1, R1, R2);
      6'd23: w = alu(OP_LOG, R1, R1, R1);
      6'd24: w = alu(OP_SUB, R0, R0, R1);
      6'd25: w = alu(OP_SUB, R0, R0, RW);
      6'd26: w = ld(R1, S_KE);
      6'd27: w = alu(OP_ADD, R0, R0, R1);
      6'd28: w = ld(R1, S_SKIN);
      6'd29: w = alu(OP_ADD, R0, R0, R1);
      6'd30: w = jmp(OP_JMP, C_NONPOS, R0, L_AXBAD);
      6'd31: w = ld(R1, S_K1);
      6'd32: w = ld(R2, S_K2);
      6'd33: w = alu(OP_MUL, R1, R1, R2);
      6'd34: w = alu(OP_SQRT, R1, R1, R1);
      6'd35: w = ld(R2, S_UF);
      6'd36: w = alu(OP_MUL, R1, R1, R2);
      6'd37: w = ld(R2, S_LEN);
      6'd38: w = ld(R3, S_TWOPI);
      6'd39: w = alu(OP_MUL, R2, R2, R3);
      6'd40: w = alu(OP_MUL, R1, R1, R2);
      6'd41: w = alu(OP_DIV, R1, R1, R0);
      6'd42: w = alu(OP_ACC, R0, R1, R0);
      6'd43: w = jmp(OP_JMP, C_ALWAYS, R0, L_NEXT);
      6'd44: w = jmp(OP_SETBAD, C_ALWAYS, R0, L_NEXT);
      6'd45: w = jmp(OP_NEXTAX, C_ALWAYS, R0, L_AXIS);
      // end of segment
      6'd46: w = jmp(OP_JMP, C_NOTLAST, R0, L_IDLE);
      6'd47: w = jmp(OP_JMP, C_BAD, R0, L_EMIT);
      6'd48: w = ld(R0, S_SUMX);
      6'd49: w = alu(OP_MUL, R0, R0, R0);
      6'd50: w = ld(R1, S_SUMY);
      6'd51: w = alu(OP_MUL, R1, R1, R1);
      6'd52: w = alu(OP_ADD, R0, R0, R1);
      6'd53: w = ld(R1, S_SUMZ);
      6'd54: w = alu(OP_MUL, R1, R1, R1);
      6'd55: w = alu(OP_ADD, R0, R0, R1);
      6'd56: w = alu(OP_SQRT, R0, R0, R0);
      6'd57: w = alu(OP_EMIT, R0, R0, R0);
      6'd58: w = jmp(OP_SETBAD, C_ALWAYS, R0, L_LAST);
      default: w = jmp(OP_JMP, C_ALWAYS, R0, L_IDLE);
    endcase
    return w;
  endfunction

endpackage

[design/dwi_mul.sv]
module dwi_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [dwi_pkg::MW-1:0] a,
  input  logic [dwi_pkg::MW-1:0] b,
  output logic                   done,
  output logic [dwi_pkg::DW-1:0] prod
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [dwi_pkg::MW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [dwi_pkg::DW-1:0] acc_r, acc_nxt;
  logic [dwi_pkg::MW+dwi_pkg::MDIG-1:0] pp;

  // one 8-bit digit of b per cycle, msb digit first
  assign pp = (dwi_pkg::MW+dwi_pkg::MDIG)'(a_r) *
              (dwi_pkg::MW+dwi_pkg::MDIG)'(b_r[dwi_pkg::MW-1 -: dwi_pkg::MDIG]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'(dwi_pkg::MUL_STEPS);
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = (acc_r << dwi_pkg::MDIG) + dwi_pkg::DW'(pp);
      b_nxt   = b_r << dwi_pkg::MDIG;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[design/dwi_sqrt.sv]
module dwi_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [dwi_pkg::SQW-1:0] x,
  output logic                    done,
  output logic [dwi_pkg::RTW-1:0] root
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic [dwi_pkg::SQW-1:0]   x_r, x_nxt;
  logic [dwi_pkg::RTW-1:0]   root_r, root_nxt;
  logic [dwi_pkg::RTW+1:0]   rem_r, rem_nxt, rem2, trial;

  // restoring root, two radicand bits per cycle
  assign rem2  = {rem_r[dwi_pkg::RTW-1:0], x_r[dwi_pkg::SQW-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(dwi_pkg::RTW);
      x_nxt    = x;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      x_nxt = x_r << 2;
      if (rem2 >= trial) begin
        rem_nxt  = rem2 - trial;
        root_nxt = {root_r[dwi_pkg::RTW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2;
        root_nxt = {root_r[dwi_pkg::RTW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[design/dwi_log2.sv]
module dwi_log2 (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [dwi_pkg::LW-1:0]  x,
  output logic                    done,
  output logic [dwi_pkg::LGW-1:0] lg
);

  dwi_pkg::lg_state_t st_r, st_nxt;

  logic                  done_r, done_nxt;
  logic [dwi_pkg::LW-1:0] nx_r, nx_nxt;
  logic [6:0]            p_r, p_nxt;
  logic [31:0]           m_r, m_nxt;
  logic [dwi_pkg::FRAC_BITS-1:0] fr_r, fr_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [63:0]           mm;
  logic [32:0]           t;
  logic                  norm_done, iter_last;

  assign mm = 64'(m_r) * 64'(m_r);
  assign t  = mm[63:31];
  assign norm_done = !((nx_r[dwi_pkg::LW-1 -: 8] == 8'd0) && (p_r >= 7'd8)) &&
                     !(!nx_r[dwi_pkg::LW-1] && (p_r != 7'd0));
  assign iter_last = (cnt_r == 5'd1);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dwi_pkg::LG_IDLE: if (start) st_nxt = dwi_pkg::LG_NORM;
      dwi_pkg::LG_NORM: if (norm_done) st_nxt = dwi_pkg::LG_ITER;
      dwi_pkg::LG_ITER: if (iter_last) st_nxt = dwi_pkg::LG_IDLE;
      default:          st_nxt = dwi_pkg::LG_IDLE;
    endcase
  end

  always_comb begin
    done_nxt = 1'b0;
    nx_nxt   = nx_r;
    p_nxt    = p_r;
    m_nxt    = m_r;
    fr_nxt   = fr_r;
    cnt_nxt  = cnt_r;
    case (st_r)
      dwi_pkg::LG_IDLE: begin
        if (start) begin
          nx_nxt = x;
          p_nxt  = 7'(dwi_pkg::LW - 1);
        end
      end
      dwi_pkg::LG_NORM: begin
        // leading-one search: byte steps, then bit steps
        if (nx_r[dwi_pkg::LW-1 -: 8] == 8'd0 && p_r >= 7'd8) begin
          nx_nxt = nx_r << 8;
          p_nxt  = p_r - 7'd8;
        end else if (!nx_r[dwi_pkg::LW-1] && p_r != 7'd0) begin
          nx_nxt = nx_r << 1;
          p_nxt  = p_r - 7'd1;
        end else begin
          m_nxt   = nx_r[dwi_pkg::LW-1 -: 32];
          cnt_nxt = 5'(dwi_pkg::FRAC_BITS);
        end
      end
      dwi_pkg::LG_ITER: begin
        // square the mantissa; overflow past 2.0 yields a fraction bit
        if (t[32]) begin
          m_nxt  = t[32:1];
          fr_nxt = {fr_r[dwi_pkg::FRAC_BITS-2:0], 1'b1};
        end else begin
          m_nxt  = t[31:0];
          fr_nxt = {fr_r[dwi_pkg::FRAC_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (iter_last) done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= dwi_pkg::LG_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r <= nx_nxt;
    p_r  <= p_nxt;
    m_r  <= m_nxt;
    fr_r <= fr_nxt;
  end

  assign done = done_r;
  assign lg   = {p_r, fr_r};

endmodule

[design/dwi_div.sv]
module dwi_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [dwi_pkg::DVW-1:0]  num,
  input  logic [dwi_pkg::DSW-1:0]  den,
  output logic                     done,
  output logic [dwi_pkg::SUMW-1:0] quo
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [6:0]               cnt_r, cnt_nxt;
  logic [dwi_pkg::DVW-1:0]  n_r, n_nxt;
  logic [dwi_pkg::DSW-1:0]  d_r, d_nxt;
  logic [dwi_pkg::DSW:0]    rem_r, rem_nxt, rem2;
  logic [dwi_pkg::QW-1:0]   q_r, q_nxt;

  // quotient bits below 2^30 are never needed, so the loop stops there
  assign rem2 = {rem_r[dwi_pkg::DSW-1:0], n_r[dwi_pkg::DVW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'(dwi_pkg::QW);
      n_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (rem2 >= {1'b0, d_r}) begin
        rem_nxt = rem2 - {1'b0, d_r};
        q_nxt   = {q_r[dwi_pkg::QW-2:0], 1'b1};
      end else begin
        rem_nxt = rem2;
        q_nxt   = {q_r[dwi_pkg::QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = (q_r[dwi_pkg::QW-1:dwi_pkg::SUMW] != '0) ? '1 : q_r[dwi_pkg::SUMW-1:0];

endmodule

[design/directional_well_index_core.sv]
// channel | dir | handshake                     | payload
// cfg     | in  | cfg_we                        | cfg_wdata: unit_factor
// in      | in  | in_tvalid / in_tready         | in_tdata, in_tlast = last_segment
// out     | out | out_tvalid / out_tready       | out_tdata = well_index, out_tuser = invalid
//
// A microcode program steps a shared multiplier, root, log2 and divider, one digit or bit
// per cycle; a segment with zero permeability or radius skips the axis bodies and only
// marks the cell invalid.
// A last segment adds the root of the summed squares (valid cells only) and its emit.
// Reset is synchronous; afterwards the block is ready at once. A result waiting on
// out_tready holds the sequencer only at its emit step.
module directional_well_index_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,   // unit_factor
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [247:0] in_tdata,    // lx, ly, lz, sx, sy, sz, kx, ky, kz, rw[16], skin[14], pad
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,   // well_index
  output logic         out_tuser    // invalid
);

  dwi_pkg::cw_t  cw;
  dwi_pkg::seg_t seg_r, seg_in;
  logic          last_r;

  logic [dwi_pkg::PCW-1:0]  pc_r, pc_nxt, step;
  logic                     wait_r, wait_nxt;
  logic [1:0]               axis_r, axis_nxt;
  logic                     bad_r, bad_nxt;
  logic [dwi_pkg::SUMW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [23:0]              uf_r;
  logic [dwi_pkg::DW-1:0]   r0_r, r0_nxt, r1_r, r1_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  logic [dwi_pkg::DW-1:0]   rw_r, rw_nxt;
  logic                     ov_r, ov_nxt;
  logic [31:0]              od_r, od_nxt;
  logic                     oi_r, oi_nxt;

  logic [dwi_pkg::DW-1:0]   opa, opb, ld_val, wr_val, unit_res;
  logic                     wr_en, unit_done, cond_ok;
  logic signed [36:0]       skin_term;
  logic [dwi_pkg::SUMW-1:0] cur_sum, acc_new;
  logic [dwi_pkg::SUMW:0]   acc_sum;

  logic mul_go, sqrt_go, log_go, div_go;
  logic mul_done, sqrt_done, log_done, div_done;
  logic [dwi_pkg::DW-1:0]   mul_p;
  logic [dwi_pkg::RTW-1:0]  sqrt_r;
  logic [dwi_pkg::LGW-1:0]  log_r;
  logic [dwi_pkg::SUMW-1:0] div_q;

  assign cw = dwi_pkg::ucode(pc_r);

  assign seg_in.lx   = in_tdata[23:0];
  assign seg_in.ly   = in_tdata[47:24];
  assign seg_in.lz   = in_tdata[71:48];
  assign seg_in.sx   = in_tdata[95:72];
  assign seg_in.sy   = in_tdata[119:96];
  assign seg_in.sz   = in_tdata[143:120];
  assign seg_in.kx   = in_tdata[167:144];
  assign seg_in.ky   = in_tdata[191:168];
  assign seg_in.kz   = in_tdata[215:192];
  assign seg_in.rw   = in_tdata[231:216];
  assign seg_in.skin = in_tdata[245:232];

  assign in_tready  = (cw.op == dwi_pkg::OP_WAIT);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = oi_r;

  assign skin_term = 37'($signed(seg_r.skin)) * $signed({14'b0, dwi_pkg::LOG2E_Q22});

  always_comb begin
    case (cw.sa)
      dwi_pkg::R0: opa = r0_r;
      dwi_pkg::R1: opa = r1_r;
      dwi_pkg::R2: opa = r2_r;
      dwi_pkg::R3: opa = r3_r;
      dwi_pkg::RW: opa = rw_r;
      default:     opa = '0;
    endcase
    case (cw.sb)
      dwi_pkg::R0: opb = r0_r;
      dwi_pkg::R1: opb = r1_r;
      dwi_pkg::R2: opb = r2_r;
      dwi_pkg::R3: opb = r3_r;
      dwi_pkg::RW: opb = rw_r;
      default:     opb = '0;
    endcase
  end

  // axis x: (sy, sz, ky, kz), y: (sx, sz, kx, kz), z: (sx, sy, kx, ky)
  always_comb begin
    case (cw.src)
      dwi_pkg::S_D1:    ld_val = dwi_pkg::DW'((axis_r == dwi_pkg::AX_X) ? seg_r.sy : seg_r.sx);
      dwi_pkg::S_D2:    ld_val = dwi_pkg::DW'((axis_r == dwi_pkg::AX_Z) ? seg_r.sy : seg_r.sz);
      dwi_pkg::S_K1:    ld_val = dwi_pkg::DW'((axis_r == dwi_pkg::AX_X) ? seg_r.ky : seg_r.kx);
      dwi_pkg::S_K2:    ld_val = dwi_pkg::DW'((axis_r == dwi_pkg::AX_Z) ? seg_r.ky : seg_r.kz);
      dwi_pkg::S_LEN:   ld_val = dwi_pkg::DW'((axis_r == dwi_pkg::AX_X) ? seg_r.lx :
                                              (axis_r == dwi_pkg::AX_Y) ? seg_r.ly : seg_r.lz);
      dwi_pkg::S_RW:    ld_val = dwi_pkg::DW'(seg_r.rw);
      dwi_pkg::S_KE:    ld_val = dwi_pkg::DW'(dwi_pkg::KE_Q30);
      dwi_pkg::S_SKIN:  ld_val = {{(dwi_pkg::DW-37){skin_term[36]}}, skin_term};
      dwi_pkg::S_UF:    ld_val = dwi_pkg::DW'(uf_r);
      dwi_pkg::S_TWOPI: ld_val = dwi_pkg::DW'(dwi_pkg::TWOPI_LN2_Q24);
      dwi_pkg::S_SUMX:  ld_val = dwi_pkg::DW'(sx_r);
      dwi_pkg::S_SUMY:  ld_val = dwi_pkg::DW'(sy_r);
      dwi_pkg::S_SUMZ:  ld_val = dwi_pkg::DW'(sz_r);
      default:          ld_val = '0;
    endcase
  end

  always_comb begin
    case (cw.cond)
      dwi_pkg::C_ALWAYS:  cond_ok = 1'b1;
      dwi_pkg::C_INBAD:   cond_ok = (seg_r.kx == '0) || (seg_r.ky == '0) ||
                                    (seg_r.kz == '0) || (seg_r.rw == '0);
      dwi_pkg::C_ZERO:    cond_ok = (opa == '0);
      dwi_pkg::C_NONPOS:  cond_ok = opa[dwi_pkg::DW-1] || (opa == '0);
      dwi_pkg::C_NOTLAST: cond_ok = !last_r;
      dwi_pkg::C_BAD:     cond_ok = bad_r;
      default:            cond_ok = 1'b0;
    endcase
  end

  assign mul_go  = !wait_r && (cw.op == dwi_pkg::OP_MUL);
  assign sqrt_go = !wait_r && (cw.op == dwi_pkg::OP_SQRT);
  assign log_go  = !wait_r && (cw.op == dwi_pkg::OP_LOG);
  assign div_go  = !wait_r && (cw.op == dwi_pkg::OP_DIV);

  dwi_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go),
    .a(opa[dwi_pkg::MW-1:0]), .b(opb[dwi_pkg::MW-1:0]),
    .done(mul_done), .prod(mul_p)
  );

  dwi_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_go),
    .x(opa[dwi_pkg::SQW-1:0]), .done(sqrt_done), .root(sqrt_r)
  );

  dwi_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .start(log_go),
    .x(opa[dwi_pkg::LW-1:0]), .done(log_done), .lg(log_r)
  );

  dwi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go),
    .num(opa[dwi_pkg::DVW-1:0]), .den(opb[dwi_pkg::DSW-1:0]),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    case (cw.op)
      dwi_pkg::OP_MUL:  begin unit_done = mul_done;  unit_res = mul_p;                   end
      dwi_pkg::OP_SQRT: begin unit_done = sqrt_done; unit_res = dwi_pkg::DW'(sqrt_r);    end
      dwi_pkg::OP_LOG:  begin unit_done = log_done;  unit_res = dwi_pkg::DW'(log_r);     end
      dwi_pkg::OP_DIV:  begin unit_done = div_done;  unit_res = dwi_pkg::DW'(div_q);     end
      default:          begin unit_done = 1'b0;      unit_res = '0;                      end
    endcase
  end

  always_comb begin
    case (axis_r)
      dwi_pkg::AX_X: cur_sum = sx_r;
      dwi_pkg::AX_Y: cur_sum = sy_r;
      default:       cur_sum = sz_r;
    endcase
  end
  assign acc_sum = {1'b0, cur_sum} + {1'b0, opa[dwi_pkg::SUMW-1:0]};
  assign acc_new = acc_sum[dwi_pkg::SUMW] ? '1 : acc_sum[dwi_pkg::SUMW-1:0];

  assign step = pc_r + 6'd1;

  always_comb begin
    pc_nxt   = pc_r;
    wait_nxt = wait_r;
    axis_nxt = axis_r;
    bad_nxt  = bad_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    sz_nxt   = sz_r;
    wr_en    = 1'b0;
    wr_val   = ld_val;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    oi_nxt   = oi_r;
    case (cw.op)
      dwi_pkg::OP_WAIT: begin
        if (in_tvalid) begin
          pc_nxt   = step;
          axis_nxt = dwi_pkg::AX_X;
        end
      end
      dwi_pkg::OP_LD:    begin wr_en = 1'b1; wr_val = ld_val;      pc_nxt = step; end
      dwi_pkg::OP_ADD:   begin wr_en = 1'b1; wr_val = opa + opb;   pc_nxt = step; end
      dwi_pkg::OP_SUB:   begin wr_en = 1'b1; wr_val = opa - opb;   pc_nxt = step; end
      dwi_pkg::OP_SHR1:  begin wr_en = 1'b1; wr_val = opa >> 1;    pc_nxt = step; end
      dwi_pkg::OP_SHL16: begin wr_en = 1'b1; wr_val = opa << 16;   pc_nxt = step; end
      dwi_pkg::OP_MUL, dwi_pkg::OP_SQRT, dwi_pkg::OP_LOG, dwi_pkg::OP_DIV: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (unit_done) begin
          wr_en    = 1'b1;
          wr_val   = unit_res;
          wait_nxt = 1'b0;
          pc_nxt   = step;
        end
      end
      dwi_pkg::OP_ACC: begin
        case (axis_r)
          dwi_pkg::AX_X: sx_nxt = acc_new;
          dwi_pkg::AX_Y: sy_nxt = acc_new;
          default:       sz_nxt = acc_new;
        endcase
        pc_nxt = step;
      end
      dwi_pkg::OP_SETBAD: begin
        bad_nxt = 1'b1;
        pc_nxt  = cw.tgt;
      end
      dwi_pkg::OP_JMP: pc_nxt = cond_ok ? cw.tgt : step;
      dwi_pkg::OP_NEXTAX: begin
        if (axis_r != dwi_pkg::AX_Z) begin
          axis_nxt = axis_r + 2'd1;
          pc_nxt   = cw.tgt;
        end else begin
          pc_nxt = step;
        end
      end
      dwi_pkg::OP_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt  = 1'b1;
          oi_nxt  = bad_r;
          od_nxt  = bad_r ? 32'd0 :
                    (opa[dwi_pkg::DW-1:32] != '0) ? 32'hFFFF_FFFF : opa[31:0];
          sx_nxt  = '0;
          sy_nxt  = '0;
          sz_nxt  = '0;
          bad_nxt = 1'b0;
          pc_nxt  = dwi_pkg::L_IDLE;
        end
      end
      default: pc_nxt = dwi_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    r0_nxt = r0_r;
    r1_nxt = r1_r;
    r2_nxt = r2_r;
    r3_nxt = r3_r;
    rw_nxt = rw_r;
    if (wr_en) begin
      case (cw.dst)
        dwi_pkg::R0: r0_nxt = wr_val;
        dwi_pkg::R1: r1_nxt = wr_val;
        dwi_pkg::R2: r2_nxt = wr_val;
        dwi_pkg::R3: r3_nxt = wr_val;
        dwi_pkg::RW: rw_nxt = wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= dwi_pkg::L_IDLE;
      wait_r <= 1'b0;
      axis_r <= dwi_pkg::AX_X;
      bad_r  <= 1'b0;
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
      uf_r   <= dwi_pkg::UF_RESET;
      ov_r   <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      wait_r <= wait_nxt;
      axis_r <= axis_nxt;
      bad_r  <= bad_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      sz_r   <= sz_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we) uf_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    r3_r <= r3_nxt;
    rw_r <= rw_nxt;
    od_r <= od_nxt;
    oi_r <= oi_nxt;
    if (in_tvalid && in_tready) begin
      seg_r  <= seg_in;
      last_r <= in_tlast;
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] LOG2_028 = -64'sd1971928221;
  localparam logic [79:0] MASK40 = (80'd1 << 40) - 1;
  localparam int MAX_CYCLES = 10000000;

  typedef struct {
    logic [23:0] lx, ly, lz, sx, sy, sz, kx, ky, kz;
    logic [15:0] rw;
    logic [13:0] skin;
    logic        last;
  } seg_item_t;

  typedef struct {
    logic [31:0] wi;
    logic        inv;
  } wi_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [23:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [247:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         out_tuser;

  directional_well_index_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [23:0] uf;
  logic [39:0] acc_x, acc_y, acc_z;
  logic        cell_bad;

  seg_item_t  seg_q[$];
  wi_result_t wi_q[$];
  int errors;
  int cycles;
  bit idle_on;
  bit in_acc;

  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (128'(t) * 128'(t) <= n) r = t;
    end
    return r;
  endfunction

  // Q30 base-2 log by repeated squaring of a 32-bit mantissa
  function automatic logic [63:0] log2_q30(logic [127:0] x);
    int p;
    logic [63:0] m;
    logic [63:0] res;
    p = 0;
    for (int i = 127; i >= 0; i--)
      if (x[i] && p == 0) p = i;
    if (p >= 31) m = 64'((x >> (p - 31)) & 128'hFFFFFFFF);
    else m = 64'(x << (31 - p));
    res = 64'(p) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic bit axis_wi(logic [23:0] len, logic [23:0] d1, logic [23:0] d2,
                                 logic [23:0] k1, logic [23:0] k2, logic [15:0] rw,
                                 logic [13:0] skin, output logic [39:0] wi);
    logic [127:0] a;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0] sk;
    logic [63:0] g;
    logic signed [63:0] e;
    wi = 0;
    a = 128'(d1) * d1 * k2 + 128'(d2) * d2 * k1;
    if (a == 0) return 1'b0;
    sk = int_sqrt(128'(k1) << 16) + int_sqrt(128'(k2) << 16);
    e = $signed(log2_q30(a) >> 1) - $signed(log2_q30(128'(sk)))
        - $signed(log2_q30(128'(rw))) + (64'sd12 <<< 30) + $signed(LOG2_028)
        + 64'($signed(skin)) * 64'sd6051102;
    if (e <= 0) return 1'b0;
    g = int_sqrt(128'(k1) * k2);
    num = 128'(uf) * g * len * 128'd152080770;
    quo = num / 128'(e);
    quo = quo >> 30;
    wi = (quo > 128'(MASK40)) ? MASK40[39:0] : quo[39:0];
    return 1'b1;
  endfunction

  function automatic logic [39:0] sat40(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = a + b;
    return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

  function automatic void predict_segment(seg_item_t s);
    logic [39:0] w;
    logic [127:0] ss;
    logic [63:0] r;
    wi_result_t res;
    if (s.kx == 0 || s.ky == 0 || s.kz == 0 || s.rw == 0) cell_bad = 1'b1;
    else begin
      if (axis_wi(s.lx, s.sy, s.sz, s.ky, s.kz, s.rw, s.skin, w)) acc_x = sat40(acc_x, w);
      else cell_bad = 1'b1;
      if (axis_wi(s.ly, s.sx, s.sz, s.kx, s.kz, s.rw, s.skin, w)) acc_y = sat40(acc_y, w);
      else cell_bad = 1'b1;
      if (axis_wi(s.lz, s.sx, s.sy, s.kx, s.ky, s.rw, s.skin, w)) acc_z = sat40(acc_z, w);
      else cell_bad = 1'b1;
    end
    if (!s.last) return;
    if (cell_bad) begin
      res.wi = 0;
      res.inv = 1'b1;
    end else begin
      ss = 128'(acc_x) * acc_x + 128'(acc_y) * acc_y + 128'(acc_z) * acc_z;
      r = int_sqrt(ss);
      res.wi = (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
      res.inv = 1'b0;
    end
    wi_q = {wi_q, res};
    acc_x = 0; acc_y = 0; acc_z = 0;
    cell_bad = 1'b0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic logic [23:0] rnd24();
    case ($urandom_range(0, 5))
      0: return 24'hFFFFFF;
      1: return 24'(1 << $urandom_range(0, 23));
      2: return 24'($urandom_range(1, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic seg_item_t rand_seg(bit last);
    seg_item_t s;
    s.lx = rnd24(); s.ly = rnd24(); s.lz = rnd24();
    s.sx = rnd24(); s.sy = rnd24(); s.sz = rnd24();
    s.kx = rnd24(); s.ky = rnd24(); s.kz = rnd24();
    s.rw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 65535));
    s.skin = ($urandom_range(0, 3) == 0) ? 14'($urandom) :
             14'($signed($urandom_range(0, 2048)) - 1024);
    if ($urandom_range(0, 30) == 0) s.kz = 0;
    if ($urandom_range(0, 30) == 0) s.sy = 0;
    s.last = last;
    return s;
  endfunction

  // driver: a word stays on the bus until the edge that accepts it
  always @(negedge clk) begin
    if (!rst_n) in_tvalid <= 1'b0;
    else if (in_tvalid && !in_acc) begin
    end else if (seg_q.size() > 0 && (idle_on == 0 || $urandom_range(0, 99) >= 33)) begin
      seg_item_t s;
      s = seg_q.pop_front();
      predict_segment(s);
      in_tdata <= {2'd0, s.skin, s.rw, s.kz, s.ky, s.kx, s.sz, s.sy, s.sx,
                   s.lz, s.ly, s.lx};
      in_tlast <= s.last;
      in_tvalid <= 1'b1;
    end else in_tvalid <= 1'b0;
  end

  always @(negedge clk)
    out_tready <= rst_n && (idle_on == 0 || $urandom_range(0, 99) >= 33);

  // monitor
  always @(posedge clk) begin
    cycles++;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (wi_q.size() == 0) begin
        report("unexpected word", out_tdata, 32'd0);
      end else begin
        wi_result_t e;
        e = wi_q.pop_front();
        if (out_tdata !== e.wi) report("well_index", out_tdata, e.wi);
        if (out_tuser !== e.inv) report("invalid", 32'(out_tuser), 32'(e.inv));
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (seg_q.size() > 0 || in_tvalid || wi_q.size() > 0) @(posedge clk);
    repeat (1400) @(posedge clk);
  endtask

  task automatic write_uf(logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    uf = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    seg_item_t s;
    logic [23:0] uf_set[4];
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 0; in_tvalid = 1'b0;
    in_tdata = 0; in_tlast = 1'b0; out_tready = 1'b0;
    uf = dwi_pkg::UF_RESET; acc_x = 0; acc_y = 0; acc_z = 0; cell_bad = 1'b0;
    errors = 0; cycles = 0; idle_on = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: typical cell, extremes, each invalid case
    s = rand_seg(1);
    s.lx = 24'd40960; s.ly = 24'd4096; s.lz = 24'd0;
    s.sx = 24'd409600; s.sy = 24'd409600; s.sz = 24'd40960;
    s.kx = 24'd25600; s.ky = 24'd25600; s.kz = 24'd2560;
    s.rw = 16'd6000; s.skin = 0;
    seg_q = {seg_q, s};
    s.skin = 14'h1FFF; seg_q = {seg_q, s};
    s.skin = 14'h2000; seg_q = {seg_q, s};
    s.last = 0; seg_q = {seg_q, s};
    s.kx = 24'hFFFFFF; s.ky = 24'hFFFFFF; s.kz = 24'hFFFFFF;
    s.lx = 24'hFFFFFF; s.ly = 24'hFFFFFF; s.lz = 24'hFFFFFF;
    s.sx = 24'hFFFFFF; s.sy = 24'hFFFFFF; s.sz = 24'hFFFFFF;
    s.rw = 16'd1; s.skin = 14'h1FFF; s.last = 1; seg_q = {seg_q, s};
    s.kx = 0; seg_q = {seg_q, s};
    s.kx = 24'd1; s.rw = 0; seg_q = {seg_q, s};
    s.rw = 16'hFFFF; s.sx = 0; s.sy = 0; seg_q = {seg_q, s};
    s.sx = 24'd1; s.sy = 24'd1; s.sz = 24'd1; s.kx = 24'd1; s.ky = 24'd1; s.kz = 24'd1;
    s.skin = 14'h2000; seg_q = {seg_q, s};
    s = rand_seg(1); s.sx = 0; s.sy = 0; s.sz = 0; seg_q = {seg_q, s};
    wait_drained();

    uf_set = '{24'hFFFFFF, 24'd0, 24'd1, dwi_pkg::UF_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_uf(uf_set[ph]);
      idle_on = (ph != 1);
      for (int n = 0; n < 360; n++)
        seg_q = {seg_q, rand_seg($urandom_range(0, 2) == 0)};
      s = rand_seg(1);
      seg_q = {seg_q, s};
      wait_drained();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
design/dwi_pkg.sv
design/dwi_mul.sv
design/dwi_sqrt.sv
design/dwi_log2.sv
design/dwi_div.sv
design/directional_well_index_core.sv
bench/tb.sv
